### sv/cdq_pkg.sv
// shared types, codes and defaults for the circular double-ended queue
package cdq_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    // fixed field widths of the stream payload
    localparam int OPCODE_W = 2;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;
    localparam int OUT_TDATA_W = 48;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_REAR  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_REAR   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic exec;
        logic load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

### sv/cdq_ctrl.sv
// controller state machine for the circular double-ended queue
module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_LOAD = 1'b1;

    logic [0:0] r_state;
    logic [0:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                // wait for the output register to drain before loading
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### sv/cdq_datapath.sv
// pointers, occupancy count, slot store and output register of the queue
module cdq_datapath
    import cdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  logic [OPCODE_W-1:0]    i_opcode,
    input  logic [WORD_W-1:0]      i_data_in,
    input  logic                   i_m_tready,
    output logic                   o_m_tvalid,
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    logic [PTR_W-1:0]    r_front;
    logic [PTR_W-1:0]    r_rear;
    logic [CNT_W-1:0]    r_count;
    logic [PTR_W-1:0]    n_front;
    logic [PTR_W-1:0]    n_rear;
    logic [CNT_W-1:0]    n_count;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    logic                r_pop_ok;
    logic                n_pop_ok;
    logic [DATA_WIDTH-1:0] r_rd_data;

    logic                wr_en;
    logic                rd_en;
    logic [PTR_W-1:0]    wr_addr;
    logic [PTR_W-1:0]    rd_addr;
    logic [DATA_WIDTH-1:0] wr_data;

    logic [PTR_W-1:0]    front_up;
    logic [PTR_W-1:0]    front_down;
    logic [PTR_W-1:0]    rear_up;
    logic [PTR_W-1:0]    rear_down;
    logic                at_front;

    logic                r_out_valid;
    logic [WORD_W-1:0]   r_out_removed;
    logic [STATUS_W-1:0] r_out_status;
    logic [OCC_W-1:0]    r_out_occ;
    logic                r_out_full;
    logic                r_out_empty;

    assign front_up   = (r_front == PTR_LAST) ? '0 : r_front + 1'b1;
    assign front_down = (r_front == '0) ? PTR_LAST : r_front - 1'b1;
    assign rear_up    = (r_rear == PTR_LAST) ? '0 : r_rear + 1'b1;
    assign rear_down  = (r_rear == '0) ? PTR_LAST : r_rear - 1'b1;
    assign at_front   = (i_opcode == OP_PUSH_FRONT) || (i_opcode == OP_POP_FRONT);
    assign wr_data    = DATA_WIDTH'($unsigned(i_data_in));

    always_comb begin
        n_front  = r_front;
        n_rear   = r_rear;
        n_count  = r_count;
        n_status = ST_DONE;
        n_pop_ok = 1'b0;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        wr_addr  = '0;
        rd_addr  = at_front ? r_front : r_rear;
        if (i_cmd.exec) begin
            case (i_opcode)
                OP_PUSH_FRONT, OP_PUSH_REAR: begin
                    if (r_count == CNT_FULL) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        n_count = r_count + 1'b1;
                        if (r_count == '0) begin
                            // first word always lands in slot 0
                            n_front = '0;
                            n_rear  = '0;
                            wr_addr = '0;
                        end else if (at_front) begin
                            n_front = front_down;
                            wr_addr = front_down;
                        end else begin
                            n_rear  = rear_up;
                            wr_addr = rear_up;
                        end
                    end
                end
                OP_POP_FRONT, OP_POP_REAR: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        rd_en    = 1'b1;
                        n_pop_ok = 1'b1;
                        n_count  = r_count - 1'b1;
                        if (r_count == CNT_W'(1)) begin
                            n_front = '0;
                            n_rear  = '0;
                        end else if (at_front) begin
                            n_front = front_up;
                        end else begin
                            n_rear  = rear_down;
                        end
                    end
                end
                default: begin
                    n_status = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_rear  <= '0;
            r_count <= '0;
        end else begin
            r_front <= n_front;
            r_rear  <= n_rear;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
        end
    end

    // slot store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_removed <= r_pop_ok ? WORD_W'(r_rd_data) : '0;
            r_out_status  <= r_status;
            r_out_occ     <= OCC_W'(r_count);
            r_out_full    <= (r_count == CNT_FULL);
            r_out_empty   <= (r_count == '0);
        end
    end

    assign o_stat.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = {7'd0, r_out_empty, r_out_full, r_out_occ, r_out_status,
                              r_out_removed};

endmodule

### sv/circular_double_ended_queue_core.sv
// top level of the circular double-ended queue
//
// A double-ended queue of DEPTH words in a circular store. Each input
// transaction carries an opcode in tuser (push front, push rear, pop front,
// pop rear) and a word in tdata, and produces exactly one output transaction
// with the popped word (zero on a push or a rejected pop), a status (done,
// full, empty), the occupancy after the operation and full/empty flags. An
// operation runs in order after acceptance: first the pointers are updated
// and the store is accessed, whose read port is registered, then the read
// word moves into the output register once that register is free. The next
// transaction is accepted once the result sits in the output register, so
// a new operation is not taken before the last one has been loaded there.
// No clearing pass is needed after reset.
module circular_double_ended_queue_core
    import cdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [WORD_W-1:0]      i_s_tdata,   // data_in[31:0]
    input  logic [OPCODE_W-1:0]    i_s_tuser,   // opcode[1:0]
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // removed_value[31:0], status[33:32], occupancy[38:34], is_full[39],
    // is_empty[40], zero[47:41]
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    t_cmd  cmd;
    t_stat stat;

    cdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_opcode   (i_s_tuser),
        .i_data_in  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
